>>> rtl/tls_pkg.sv
// Package for the tunable laser supervisor: field widths, command words,
// operation codes, scan status bits and the checksum function. No dependencies.
package tls_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned QAddrW = $clog2(QueueDepth);
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);

  localparam logic [1:0] OpTick   = 2'd0;
  localparam logic [1:0] OpStart  = 2'd1;
  localparam logic [1:0] OpToggle = 2'd2;

  localparam logic [2:0] CfgPower = 3'd0;
  localparam logic [2:0] CfgStart = 3'd1;
  localparam logic [2:0] CfgEnd   = 3'd2;
  localparam logic [2:0] CfgStep  = 3'd3;
  localparam logic [2:0] CfgDwell = 3'd4;

  localparam logic [31:0] CmdEnable  = 32'h8132_0008;
  localparam logic [31:0] CmdDisable = 32'h0132_0000;
  localparam logic [31:0] CmdPower   = 32'h0131_0000;
  localparam logic [31:0] CmdThz     = 32'h0135_0000;
  localparam logic [31:0] CmdFrac    = 32'h0136_0000;
  localparam logic [31:0] CmdNop     = 32'h0000_0000;

  // Six status queries sent after every refill.
  localparam logic [31:0] QueryCmds [6] = '{
    32'h0000_0000, 32'h1032_0000, 32'h4040_0000,
    32'h5041_0000, 32'h6042_0000, 32'h7043_0000
  };

  localparam logic [7:0] RegNop  = 8'h00;
  localparam logic [7:0] RegRes  = 8'h32;
  localparam logic [7:0] RegFThz = 8'h40;
  localparam logic [7:0] RegFrac = 8'h41;
  localparam logic [7:0] RegPwr  = 8'h42;
  localparam logic [7:0] RegTemp = 8'h43;

  localparam int unsigned StPending = 0;
  localparam int unsigned StDown    = 1;
  localparam int unsigned StLast    = 2;

  localparam logic [21:0] FreqDiv = 22'd10000;

  typedef struct packed {
    logic [1:0]  op;
    logic        port_open;
    logic        rx_valid;
    logic [31:0] rx_frame;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [31:0] tx_frame;
    logic        link_open;
    logic        laser_alive;
    logic        output_on;
    logic        output_stable;
    logic        report;
    logic [7:0]  freq_whole;
    logic [15:0] freq_fraction;
    logic [15:0] power_read;
    logic [15:0] temp_read;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // BIP-4 checksum nibble inserted into bits 31..28.
  function automatic logic [31:0] bip4(input logic [31:0] f);
    logic [7:0] x;
    x = {4'd0, f[27:24]} ^ f[23:16] ^ f[15:8] ^ f[7:0];
    return {x[7:4] ^ x[3:0], f[27:0]};
  endfunction

endpackage

>>> rtl/tls_if.sv
// Valid/ready channel interfaces for the tunable laser supervisor.
// Depends on tls_pkg for the payload types.
interface tls_in_if (input logic clk_i);
  import tls_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tls_out_if (input logic clk_i);
  import tls_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tls_cfg_if (input logic clk_i);
  import tls_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/tls_divmod.sv
// Split of a 22-bit frequency into THz and 0.1 GHz fraction by reciprocal multiplication.
// Depends on tls_pkg.
module tls_divmod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [21:0] value_i,
  output logic        done_o,
  output logic [7:0]  whole_o,
  output logic [13:0] frac_o
);
  import tls_pkg::*;

  // ceil(2^34 / 10000); exact quotient for every 22-bit value.
  localparam logic [20:0] RecipMul = 21'd1717987;

  logic [21:0] val_q;
  logic [8:0]  quo_q;
  logic [13:0] rem_q;
  logic        busy_q;
  logic        done_q;
  logic [42:0] prod;
  logic [21:0] back;
  logic [21:0] diff;

  // First step: quotient from the reciprocal product.
  assign prod = {21'd0, value_i} * {22'd0, RecipMul};
  // Second step: remainder from the quotient.
  assign back = {13'd0, quo_q} * FreqDiv;
  assign diff = val_q - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      quo_q <= prod[42:34];
    end
    if (busy_q) rem_q <= diff[13:0];
  end

  assign done_o  = done_q;
  assign whole_o = quo_q[7:0];
  assign frac_o  = rem_q;
endmodule

>>> rtl/tunable_laser_supervisor.sv
// Supervisor for a tunable laser: every tick item parses the reply it carries,
// updates the link and output flags and readbacks and, while the port is open,
// refills the command queue when empty and sends one queued command with its
// checksum. One item is taken at a time. A tick that loads a new scan point runs
// the reciprocal divide into THz and fraction and then writes twelve entries
// through the single write port of the command memory (one entry a cycle); a
// tick that reloads only the queries writes six or seven. The result register
// frees the input side as soon as the result is loaded; while the output is
// stalled the next item waits in its result state until the register drains.
module tunable_laser_supervisor (
  input  logic clk_i,
  input  logic rst_ni,
  tls_in_if.sink    in_if,
  tls_out_if.source out_if,
  tls_cfg_if.sink   cfg_if
);
  import tls_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SPoint  = 4'd1;
  localparam logic [3:0] SDiv    = 4'd2;
  localparam logic [3:0] SFill   = 4'd3;
  localparam logic [3:0] SRead   = 4'd4;
  localparam logic [3:0] SSend   = 4'd5;
  localparam logic [3:0] SResult = 4'd6;

  // Configuration registers.
  logic [15:0] power_q, step_q, dwell_q;
  logic [21:0] start_q, end_q;

  // Block state.
  logic [3:0]  state_q;
  logic        alive_q, out_q, stable_q, open_q, want_en_q, want_set_q;
  logic        report_q, txv_q;
  logic [15:0] sticks_q;
  logic [7:0]  fwhole_q;
  logic [15:0] ffrac_q, pwr_q, temp_q;
  logic [21:0] snext_q;
  logic [2:0]  sstat_q;
  logic [QAddrW-1:0] head_q;
  logic [QCntW-1:0]  count_q;
  logic [31:0] txf_q;
  logic [3:0]  fill_q;
  logic [3:0]  fill_n_q;
  logic        set_seq_q;
  logic        ovalid_q;
  out_item_t   odata_q;

  // Command memory, one write and one registered read port.
  logic [31:0] qmem [QueueDepth];
  logic        qwe;
  logic [QAddrW-1:0] qwaddr;
  logic [31:0] qwdata, qrdata_q;

  always_ff @(posedge clk_i) begin
    if (qwe) qmem[qwaddr] <= qwdata;
    qrdata_q <= qmem[head_q];
  end

  // Divider for the THz and fraction split.
  logic        div_start, div_done;
  logic [7:0]  div_whole;
  logic [13:0] div_frac;
  logic [7:0]  whole_q;
  logic [13:0] frac_q;

  tls_divmod u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .value_i (snext_q),
    .done_o  (div_done),
    .whole_o (div_whole),
    .frac_o  (div_frac)
  );

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = (state_q == SIdle);
  assign out_if.valid = ovalid_q;
  assign out_if.data  = odata_q;

  logic in_acc;
  assign in_acc = in_if.valid && in_if.ready;

  // Next scan point computation.
  logic [15:0] step_eff;
  logic [22:0] up_sum, dn_lim;
  assign step_eff = (step_q == '0) ? 16'd1 : step_q;
  assign up_sum   = {1'b0, snext_q} + {7'd0, step_eff};
  assign dn_lim   = {1'b0, end_q} + {7'd0, step_eff};
  assign div_start = (state_q == SPoint);

  // Fill entry chosen by fill index.
  logic [31:0] fill_word;
  always_comb begin
    fill_word = CmdNop;
    if (set_seq_q) begin
      case (fill_q)
        4'd0:    fill_word = CmdDisable;
        4'd1:    fill_word = CmdPower | {16'd0, power_q};
        4'd2:    fill_word = CmdThz | {24'd0, whole_q};
        4'd3:    fill_word = CmdFrac | {18'd0, frac_q};
        4'd4:    fill_word = CmdNop;
        4'd5:    fill_word = want_en_q ? CmdEnable : CmdDisable;
        default: fill_word = QueryCmds[3'(fill_q - 4'd6)];
      endcase
    end else begin
      if (fill_n_q == 4'd7 && fill_q == 4'd0) begin
        fill_word = want_en_q ? CmdEnable : CmdDisable;
      end else if (fill_n_q == 4'd7) begin
        fill_word = QueryCmds[3'(fill_q - 4'd1)];
      end else begin
        fill_word = QueryCmds[3'(fill_q)];
      end
    end
  end

  assign qwe    = (state_q == SFill);
  assign qwaddr = fill_q[QAddrW-1:0];
  assign qwdata = fill_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= 16'd600;
      start_q <= 22'd1898000;
      end_q   <= 22'd1898000;
      step_q  <= 16'd1000;
      dwell_q <= 16'd0;
      state_q <= SIdle;
      alive_q <= 1'b0; out_q <= 1'b0; stable_q <= 1'b0; open_q <= 1'b0;
      want_en_q <= 1'b0; want_set_q <= 1'b1;
      report_q <= 1'b0; txv_q <= 1'b0;
      sticks_q <= '0;
      fwhole_q <= '0; ffrac_q <= '0; pwr_q <= '0; temp_q <= '0;
      snext_q <= '0; sstat_q <= '0;
      head_q <= '0; count_q <= '0;
      txf_q <= '0; fill_q <= '0; fill_n_q <= '0; set_seq_q <= 1'b0;
      whole_q <= '0; frac_q <= '0;
      ovalid_q <= 1'b0;
      odata_q <= '0;
    end else begin
      if (cfg_if.valid) begin
        case (cfg_if.data.index)
          CfgPower: power_q <= cfg_if.data.data[15:0];
          CfgStart: start_q <= cfg_if.data.data[21:0];
          CfgEnd:   end_q   <= cfg_if.data.data[21:0];
          CfgStep:  step_q  <= cfg_if.data.data[15:0];
          CfgDwell: dwell_q <= cfg_if.data.data[15:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;

      case (state_q)
        SIdle: begin
          if (in_acc) begin
            logic n_open, n_alive, n_out, n_stable, rep, ws;
            logic [7:0] b1, b2, b3;
            logic [15:0] st;
            logic [3:0] nxt;
            b1 = in_if.data.rx_frame[23:16];
            b2 = in_if.data.rx_frame[15:8];
            b3 = in_if.data.rx_frame[7:0];
            n_open = open_q; n_alive = alive_q; n_out = out_q; n_stable = stable_q;
            rep = 1'b0;
            st  = sticks_q;
            ws  = want_set_q;
            nxt = SResult;
            txv_q <= 1'b0;
            txf_q <= '0;
            if (in_if.data.op == OpStart) begin
              want_en_q <= 1'b1;
              if (start_q < end_q) begin
                snext_q <= start_q;
                sstat_q <= 3'b001;
              end else if (start_q > end_q) begin
                snext_q <= start_q;
                sstat_q <= 3'b011;
              end else begin
                snext_q <= end_q;
                sstat_q <= 3'b101;
              end
            end else if (in_if.data.op == OpToggle) begin
              want_en_q <= !want_en_q;
            end else if (in_if.data.op == OpTick) begin
              if (in_if.data.port_open) begin
                n_open = 1'b1;
                if (in_if.data.rx_valid) begin
                  n_alive = 1'b1;
                  case (b1)
                    RegNop: begin
                      if (b2 == 8'h00) begin
                        if (out_q) n_stable = 1'b1;
                      end else if (b2 == 8'h01) n_stable = 1'b0;
                    end
                    RegRes: begin
                      if (b3 == 8'h08) n_out = 1'b1;
                      else if (b3 == 8'h00) n_out = 1'b0;
                    end
                    RegFThz: fwhole_q <= b3;
                    RegFrac: ffrac_q <= in_if.data.rx_frame[15:0];
                    RegPwr:  pwr_q <= in_if.data.rx_frame[15:0];
                    RegTemp: begin
                      temp_q <= in_if.data.rx_frame[15:0];
                      rep    = 1'b1;
                    end
                    default: ;
                  endcase
                end else begin
                  n_alive = 1'b0; n_out = 1'b0; n_stable = 1'b0;
                  rep = 1'b1;
                end
              end else begin
                n_open = 1'b0; n_alive = 1'b0; n_out = 1'b0; n_stable = 1'b0;
                rep = 1'b1;
              end
              open_q <= n_open; alive_q <= n_alive; out_q <= n_out;
              stable_q <= n_stable;
              if (n_stable && sticks_q != 16'hFFFF) st = sticks_q + 16'd1;
              if (n_open) begin
                if (count_q == '0) begin
                  head_q <= '0;
                  if (sstat_q[StPending] && st >= dwell_q) begin
                    ws = 1'b1;
                    st = '0;
                  end
                  fill_q <= '0;
                  if (ws && sstat_q[StPending]) begin
                    set_seq_q  <= 1'b1;
                    fill_n_q   <= 4'd12;
                    want_set_q <= 1'b0;
                    nxt = SPoint;
                  end else begin
                    set_seq_q  <= 1'b0;
                    fill_n_q   <= ws ? 4'd6 : 4'd7;
                    want_set_q <= ws;
                    nxt = SFill;
                  end
                end else begin
                  nxt = SRead;
                end
              end
              sticks_q <= st;
            end
            report_q <= rep;
            state_q  <= nxt;
          end
        end
        SPoint: begin
          // Take the pending point and advance the walk.
          if (sstat_q[StLast]) sstat_q <= '0;
          else if (sstat_q[StDown]) begin
            if ({1'b0, snext_q} <= dn_lim) begin
              sstat_q[StLast] <= 1'b1;
            end
          end else if (up_sum >= {1'b0, end_q}) begin
            sstat_q[StLast] <= 1'b1;
          end
          state_q <= SDiv;
        end
        SDiv: begin
          if (div_done) begin
            whole_q <= div_whole;
            frac_q  <= div_frac;
            if (sstat_q != 3'b000) begin
              if (sstat_q[StLast]) snext_q <= end_q;
              else if (sstat_q[StDown]) snext_q <= 22'(snext_q - {6'd0, step_eff});
              else snext_q <= up_sum[21:0];
            end
            state_q <= SFill;
          end
        end
        SFill: begin
          if (fill_q == fill_n_q - 4'd1) begin
            count_q <= QCntW'(fill_n_q);
            state_q <= SRead;
          end
          fill_q <= fill_q + 4'd1;
        end
        SRead: begin
          state_q <= SSend;
        end
        SSend: begin
          txv_q   <= 1'b1;
          txf_q   <= bip4(qrdata_q);
          head_q  <= head_q + QAddrW'(1);
          count_q <= count_q - QCntW'(1);
          state_q <= SResult;
        end
        SResult: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            odata_q  <= '{tx_valid: txv_q, tx_frame: txf_q, link_open: open_q,
                          laser_alive: alive_q, output_on: out_q,
                          output_stable: stable_q, report: report_q,
                          freq_whole: fwhole_q, freq_fraction: ffrac_q,
                          power_read: pwr_q, temp_read: temp_q};
            state_q  <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // A stalled result holds its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_if.ready) |=> (ovalid_q && $stable(odata_q)))
    else $error("result changed while stalled");
  // Queue never holds more than the memory depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= QCntW'(QueueDepth))
    else $error("queue overflow");
  // A sent frame implies the link is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && odata_q.tx_valid) |-> odata_q.link_open)
    else $error("frame sent on closed link");
endmodule
